// ===== src/mbsp_pkg.sv =====
package mbsp_pkg;

   // parse state encodings, code 7 is unused and acts as unknown
   typedef enum logic [2:0] {
      PS_UNKNOWN = 3'd0,
      PS_ONE     = 3'd1,
      PS_TWO_A   = 3'd2,
      PS_TWO_B   = 3'd3,
      PS_SX0     = 3'd4,
      PS_SX1     = 3'd5,
      PS_SX2     = 3'd6
   } parse_state_type;

   // configuration register indexes
   localparam logic [1:0] CSR_IMPLANT_ENABLE = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_NUM    = 2'd1;
   localparam logic [1:0] CSR_CAPTURE_ENABLE = 2'd2;

   // status byte codes
   localparam logic [7:0] ST_SYSEX_START = 8'hF0;
   localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
   localparam logic [7:0] ST_SONG_POS    = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
   localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
   localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
   localparam logic [7:0] ST_REALTIME    = 8'hF8;
   localparam logic [7:0] ST_ONE_LO      = 8'hC0;
   localparam logic [7:0] ST_ONE_HI      = 8'hDF;
   localparam logic [7:0] ST_STATUS_MIN  = 8'h80;

   typedef struct packed {
      logic       implant_enable;
      logic [3:0] channel_num;
      logic       capture_enable;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] len;
   } result_type;

endpackage

// ===== src/midi_byte_stream_parser_top.sv =====
// channel   direction  ports                                     transaction
// req       in         req_valid req_stall req_byte_in           one raw midi byte
// rsp       out        rsp_valid rsp_stall rsp_msg_byte0..2/len  one complete message
// csr       in         csr_write csr_index csr_data              one register write
//
// one byte is taken per cycle while req_stall is low; a message comes out the cycle
// after the byte that completes it, through a single output register
// synchronous active-high reset clears the parse state, stored bytes and config
// req_stall rises only while the output register is full and rsp is stalled,
// so a byte is still taken in the cycle the waiting message leaves
module midi_byte_stream_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_msg_byte0,
   output logic [7:0] rsp_msg_byte1,
   output logic [7:0] rsp_msg_byte2,
   output logic [1:0] rsp_msg_len,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);

   mbsp_pkg::cfg_type    cfg_ff;
   mbsp_pkg::result_type result;
   logic                 req_accept;
   logic                 rsp_valid_ff;
   logic [7:0]           byte0_ff, byte1_ff, byte2_ff;
   logic [1:0]           len_ff;

   // config registers, writes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            mbsp_pkg::CSR_IMPLANT_ENABLE: cfg_ff.implant_enable <= csr_data[0];
            mbsp_pkg::CSR_CHANNEL_NUM:    cfg_ff.channel_num    <= csr_data;
            mbsp_pkg::CSR_CAPTURE_ENABLE: cfg_ff.capture_enable <= csr_data[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // hold off input only when the result slot cannot drain this cycle
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   mbsp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .byte_in (req_byte_in),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // output register: valid is control, payload loads only with a new message
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && result.hit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result.hit) begin
         byte0_ff <= result.byte0;
         byte1_ff <= result.byte1;
         byte2_ff <= result.byte2;
         len_ff   <= result.len;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_msg_byte0 = byte0_ff;
   assign rsp_msg_byte1 = byte1_ff;
   assign rsp_msg_byte2 = byte2_ff;
   assign rsp_msg_len   = len_ff;

endmodule

// ===== src/mbsp_parser.sv =====
module mbsp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_in,
   input  mbsp_pkg::cfg_type    cfg,
   output mbsp_pkg::result_type result
);

   mbsp_pkg::parse_state_type state_ff, state_in;
   logic [7:0] b0_ff, b1_ff, b2_ff;
   logic [7:0] b0_in, b1_in, b2_in;
   logic       emit;
   logic [7:0] e0, e1, e2;
   logic [1:0] elen;
   logic [7:0] status_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbsp_pkg::PS_UNKNOWN;
         b0_ff    <= 8'h00;
         b1_ff    <= 8'h00;
         b2_ff    <= 8'h00;
      end else if (accept) begin
         state_ff <= state_in;
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         b2_ff    <= b2_in;
      end
   end

   // channel implant on status bytes
   assign status_byte = cfg.implant_enable ? {byte_in[7:4], cfg.channel_num} : byte_in;

   always_comb begin
      state_in = state_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      emit     = 1'b0;
      e0       = b0_ff;
      e1       = b1_ff;
      e2       = b2_ff;
      elen     = 2'd1;
      priority if (byte_in >= mbsp_pkg::ST_REALTIME) begin
         // real-time goes straight out, parse untouched
         emit = 1'b1;
         e0   = byte_in;
      end else if (byte_in >= mbsp_pkg::ST_SYSEX_START) begin
         priority if (byte_in == mbsp_pkg::ST_SYSEX_START) begin
            b0_in    = byte_in;
            state_in = mbsp_pkg::PS_SX1;
         end else if (byte_in == mbsp_pkg::ST_MTC_QFRAME ||
                      byte_in == mbsp_pkg::ST_SONG_SEL) begin
            b0_in    = byte_in;
            state_in = mbsp_pkg::PS_ONE;
         end else if (byte_in == mbsp_pkg::ST_SONG_POS) begin
            b0_in    = byte_in;
            state_in = mbsp_pkg::PS_TWO_A;
         end else if (byte_in == mbsp_pkg::ST_TUNE_REQ) begin
            b0_in    = byte_in;
            state_in = mbsp_pkg::PS_UNKNOWN;
            emit     = 1'b1;
            e0       = byte_in;
         end else if (byte_in == mbsp_pkg::ST_SYSEX_END) begin
            state_in = mbsp_pkg::PS_UNKNOWN;
            priority if (state_ff == mbsp_pkg::PS_SX0) begin
               b0_in = byte_in;
               emit  = 1'b1;
               e0    = byte_in;
               elen  = 2'd1;
            end else if (state_ff == mbsp_pkg::PS_SX1) begin
               b1_in = byte_in;
               emit  = 1'b1;
               e1    = byte_in;
               elen  = 2'd2;
            end else if (state_ff == mbsp_pkg::PS_SX2) begin
               b2_in = byte_in;
               emit  = 1'b1;
               e2    = byte_in;
               elen  = 2'd3;
            end else begin
               emit = 1'b0;
            end
         end else begin
            // undefined system common
            state_in = mbsp_pkg::PS_UNKNOWN;
         end
      end else if (byte_in >= mbsp_pkg::ST_STATUS_MIN) begin
         b0_in    = status_byte;
         state_in = (byte_in >= mbsp_pkg::ST_ONE_LO && byte_in <= mbsp_pkg::ST_ONE_HI)
                    ? mbsp_pkg::PS_ONE : mbsp_pkg::PS_TWO_A;
      end else begin
         // data byte
         unique case (state_ff)
            mbsp_pkg::PS_ONE: begin
               if (b0_ff >= mbsp_pkg::ST_SYSEX_START) state_in = mbsp_pkg::PS_UNKNOWN;
               b1_in = byte_in;
               emit  = 1'b1;
               e1    = byte_in;
               elen  = 2'd2;
            end
            mbsp_pkg::PS_TWO_A: begin
               b1_in    = byte_in;
               state_in = mbsp_pkg::PS_TWO_B;
            end
            mbsp_pkg::PS_TWO_B: begin
               state_in = (b0_ff < mbsp_pkg::ST_SYSEX_START)
                          ? mbsp_pkg::PS_TWO_A : mbsp_pkg::PS_UNKNOWN;
               b2_in = byte_in;
               emit  = 1'b1;
               e2    = byte_in;
               elen  = 2'd3;
            end
            mbsp_pkg::PS_SX0: begin
               b0_in    = byte_in;
               state_in = mbsp_pkg::PS_SX1;
            end
            mbsp_pkg::PS_SX1: begin
               b1_in    = byte_in;
               state_in = mbsp_pkg::PS_SX2;
            end
            mbsp_pkg::PS_SX2: begin
               b2_in    = byte_in;
               state_in = mbsp_pkg::PS_SX0;
               emit     = 1'b1;
               e2       = byte_in;
               elen     = 2'd3;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_comb begin
      result.hit   = emit & cfg.capture_enable;
      result.byte0 = e0;
      result.byte1 = (elen >= 2'd2) ? e1 : 8'h00;
      result.byte2 = (elen == 2'd3) ? e2 : 8'h00;
      result.len   = elen;
   end

endmodule

// ===== tb/sv/midi_parser_tb_pkg.sv =====
package midi_parser_tb_pkg;

   import mbsp_pkg::*;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] len;
   } midi_msg_type;

   class midi_msg_scoreboard;

      // register copies
      logic            implant_on;
      logic [3:0]      channel;
      logic            capture_on;

      // parser copy
      parse_state_type state;
      logic [7:0]      held [3];
      logic [1:0]      held_len;

      midi_msg_type    expected_msgs [$];
      int              failures;

      function new();
         implant_on = 1'b0;
         channel    = 4'h0;
         capture_on = 1'b0;
         state      = PS_UNKNOWN;
         held[0]    = 8'h00;
         held[1]    = 8'h00;
         held[2]    = 8'h00;
         held_len   = 2'd0;
         failures   = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [3:0] data);
         case (idx)
            CSR_IMPLANT_ENABLE: implant_on = data[0];
            CSR_CHANNEL_NUM:    channel    = data;
            CSR_CAPTURE_ENABLE: capture_on = data[0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_msgs.size();
      endfunction

      function void emit(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [1:0] len);
         midi_msg_type m;
         if (!capture_on)
            return;
         m.b0  = b0;
         m.b1  = (len >= 2'd2) ? b1 : 8'h00;
         m.b2  = (len == 2'd3) ? b2 : 8'h00;
         m.len = len;
         expected_msgs.push_back(m);
      endfunction

      // completed message leaves the store, length clears
      function void emit_held();
         logic [1:0] len;
         len      = held_len;
         held_len = 2'd0;
         emit(held[0], held[1], held[2], len);
      endfunction

      // advance the parser copy by one accepted byte
      function void parse_byte(logic [7:0] b);
         parse_state_type prior;
         if (b >= ST_REALTIME) begin
            emit(b, 8'h00, 8'h00, 2'd1);
         end else if (b >= ST_SYSEX_START) begin
            case (b)
               ST_SYSEX_START: begin
                  held[0] = b; held_len = 2'd1; state = PS_SX1;
               end
               ST_MTC_QFRAME, ST_SONG_SEL: begin
                  held[0] = b; held_len = 2'd1; state = PS_ONE;
               end
               ST_SONG_POS: begin
                  held[0] = b; held_len = 2'd1; state = PS_TWO_A;
               end
               ST_TUNE_REQ: begin
                  held[0] = b; held_len = 2'd1; state = PS_UNKNOWN;
                  emit_held();
               end
               ST_SYSEX_END: begin
                  prior = state;
                  state = PS_UNKNOWN;
                  case (prior)
                     PS_SX0: begin held[0] = b; held_len = 2'd1; emit_held(); end
                     PS_SX1: begin held[1] = b; held_len = 2'd2; emit_held(); end
                     PS_SX2: begin held[2] = b; held_len = 2'd3; emit_held(); end
                     default: ;
                  endcase
               end
               default: state = PS_UNKNOWN;
            endcase
         end else if (b >= ST_STATUS_MIN) begin
            held[0]  = implant_on ? {b[7:4], channel} : b;
            held_len = 2'd1;
            state    = (b >= ST_ONE_LO && b <= ST_ONE_HI) ? PS_ONE : PS_TWO_A;
         end else begin
            case (state)
               PS_ONE: begin
                  if (held[0] >= ST_SYSEX_START)
                     state = PS_UNKNOWN;
                  held[1] = b; held_len = 2'd2;
                  emit_held();
               end
               PS_TWO_A: begin
                  held[1] = b; held_len = 2'd2; state = PS_TWO_B;
               end
               PS_TWO_B: begin
                  state   = (held[0] < ST_SYSEX_START) ? PS_TWO_A : PS_UNKNOWN;
                  held[2] = b; held_len = 2'd3;
                  emit_held();
               end
               PS_SX0: begin
                  held[0] = b; held_len = 2'd1; state = PS_SX1;
               end
               PS_SX1: begin
                  held[1] = b; held_len = 2'd2; state = PS_SX2;
               end
               PS_SX2: begin
                  held[2] = b; held_len = 2'd3; state = PS_SX0;
                  emit_held();
               end
               default: ;
            endcase
         end
      endfunction

      task report_mismatch(string msg);
         failures++;
         if (failures <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_message(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [1:0] len);
         midi_msg_type want;
         if (expected_msgs.size() == 0) begin
            report_mismatch($sformatf("unexpected message %h %h %h len %0d", b0, b1, b2, len));
            return;
         end
         want = expected_msgs.pop_front();
         if (b0 !== want.b0)
            report_mismatch($sformatf("byte0 expected %h got %h", want.b0, b0));
         if (b1 !== want.b1)
            report_mismatch($sformatf("byte1 expected %h got %h", want.b1, b1));
         if (b2 !== want.b2)
            report_mismatch($sformatf("byte2 expected %h got %h", want.b2, b2));
         if (len !== want.len)
            report_mismatch($sformatf("len expected %0d got %0d", want.len, len));
      endtask

   endclass

endpackage

// ===== tb/sv/testbench.sv =====
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import mbsp_pkg::*;
   import midi_parser_tb_pkg::*;

   // status codes and the data maximum used by the stimulus that the package does not name
   localparam logic [7:0] NOTE_OFF         = 8'h80;
   localparam logic [7:0] NOTE_ON          = 8'h90;
   localparam logic [7:0] PROG_CHANGE      = 8'hC0;
   localparam logic [7:0] CHAN_STATUS_MAX  = 8'hEF;
   localparam logic [7:0] UNDEF_COMMON     = 8'hF4;
   localparam logic [7:0] RT_SYSTEM_RESET  = 8'hFF;
   localparam logic [7:0] DATA_MAX         = 8'h7F;

   // every input starts at a known value
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       csr_write   = 1'b0;
   logic [1:0] csr_index   = CSR_IMPLANT_ENABLE;
   logic [3:0] csr_data    = 4'h0;

   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_msg_byte0;
   logic [7:0] rsp_msg_byte1;
   logic [7:0] rsp_msg_byte2;
   logic [1:0] rsp_msg_len;

   midi_msg_scoreboard sb;

   // shared between sender and receiver
   bit         no_idle      = 1'b0;   // both sides run without gaps
   bit         hold_request = 1'b0;   // receiver holds off for a long stretch
   int         sent_count   = 0;
   logic [7:0] directed_seq [25];

   midi_byte_stream_parser_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_msg_byte0 (rsp_msg_byte0),
      .rsp_msg_byte1 (rsp_msg_byte1),
      .rsp_msg_byte2 (rsp_msg_byte2),
      .rsp_msg_len   (rsp_msg_len),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // monitors: both channels sampled at the edge where a transaction happens,
   // so every value seen here is the one from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.parse_byte(req_byte_in);
         if (rsp_valid && !rsp_stall)
            sb.check_message(rsp_msg_byte0, rsp_msg_byte1, rsp_msg_byte2, rsp_msg_len);
      end
   end

   // offer one byte after a random gap and hold it until taken;
   // valid stays high when the next byte follows with no gap
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_byte_in <= 8'($urandom_range(0, 255));
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // now and then a real-time byte cuts in ahead of the byte
   task automatic put_byte(input logic [7:0] b);
      if ($urandom_range(0, 19) == 0)
         send_byte(8'($urandom_range(ST_REALTIME, RT_SYSTEM_RESET)));
      send_byte(b);
   endtask

   function automatic logic [7:0] data_byte();
      return 8'($urandom_range(0, DATA_MAX));
   endfunction

   // sender pauses until every expected message has come out, then lets
   // the last byte settle before any register write
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // all three registers back to back; spare bits of the one-bit
   // registers carry junk that the block must ignore
   task automatic apply_config(input logic impl, input logic [3:0] chan, input logic cap);
      logic [3:0] junk;
      logic [3:0] d_impl;
      logic [3:0] d_cap;
      junk   = 4'($urandom_range(0, 15));
      d_impl = {junk[3:1], impl};
      junk   = 4'($urandom_range(0, 15));
      d_cap  = {junk[3:1], cap};
      csr_write <= 1'b1;
      csr_index <= CSR_IMPLANT_ENABLE;
      csr_data  <= d_impl;
      @(posedge clock);
      csr_index <= CSR_CHANNEL_NUM;
      csr_data  <= chan;
      @(posedge clock);
      csr_index <= CSR_CAPTURE_ENABLE;
      csr_data  <= d_cap;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_register(CSR_IMPLANT_ENABLE, d_impl);
      sb.write_register(CSR_CHANNEL_NUM, chan);
      sb.write_register(CSR_CAPTURE_ENABLE, d_cap);
   endtask

   // mostly well-formed messages with random content, the rest broken
   // sequences and raw noise
   task automatic send_traffic(input int n);
      int         stop_at;
      int         pick;
      int         count;
      logic [7:0] st;
      stop_at = sent_count + n;
      while (sent_count < stop_at) begin
         // occasional stretches with no gaps on either side
         if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
         if ($urandom_range(0, 59) == 0)
            wait_until_idle();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // two-data channel message, then running status repeats
            do st = 8'($urandom_range(ST_STATUS_MIN, CHAN_STATUS_MAX));
            while (st >= ST_ONE_LO && st <= ST_ONE_HI);
            put_byte(st);
            count = $urandom_range(1, 4);
            repeat (count) begin
               put_byte(data_byte());
               put_byte(data_byte());
            end
         end else if (pick < 45) begin
            // one-data channel message with running status
            put_byte(8'($urandom_range(ST_ONE_LO, ST_ONE_HI)));
            count = $urandom_range(1, 4);
            repeat (count) put_byte(data_byte());
         end else if (pick < 55) begin
            // system common
            case ($urandom_range(0, 3))
               0: begin put_byte(ST_MTC_QFRAME); put_byte(data_byte()); end
               1: begin put_byte(ST_SONG_SEL); put_byte(data_byte()); end
               2: begin
                  put_byte(ST_SONG_POS);
                  put_byte(data_byte());
                  put_byte(data_byte());
               end
               default: put_byte(ST_TUNE_REQ);
            endcase
         end else if (pick < 70) begin
            // sysex of zero to ten data bytes, closed by end of exclusive
            put_byte(ST_SYSEX_START);
            count = $urandom_range(0, 10);
            repeat (count) put_byte(data_byte());
            put_byte(ST_SYSEX_END);
         end else if (pick < 80) begin
            // truncated message, cut off by whatever comes next
            if ($urandom_range(0, 1) == 0)
               put_byte(8'($urandom_range(ST_STATUS_MIN, CHAN_STATUS_MAX)));
            else
               put_byte(8'($urandom_range(ST_SYSEX_START, ST_TUNE_REQ)));
            count = $urandom_range(0, 1);
            repeat (count) put_byte(data_byte());
         end else begin
            // noise, weighted toward the system range
            if ($urandom_range(0, 9) < 3)
               send_byte(8'($urandom_range(ST_SYSEX_START, RT_SYSTEM_RESET)));
            else
               send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // receiver: random stall per message, plus one long hold-off on request
   initial begin : receiver
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            // long hold-off while the sender keeps going, fills the block
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
         end
         n = no_idle ? 0 : $urandom_range(0, 17);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // main sequence
   initial begin : stimulus
      int i;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // directed: data with no status, note on at the data extremes,
      // a real-time byte inside a note off, program change, an undefined
      // common byte followed by stray data, tune request, end of exclusive
      // outside sysex, quarter frame with a second data byte after it (no
      // running status there), song position, and a sysex cut into chunks
      directed_seq = '{8'h45, NOTE_ON, 8'h00, DATA_MAX,
                       NOTE_OFF, 8'h11, RT_SYSTEM_RESET, 8'h22,
                       PROG_CHANGE | 8'h05, DATA_MAX,
                       UNDEF_COMMON, 8'h10,
                       ST_TUNE_REQ, ST_SYSEX_END,
                       ST_MTC_QFRAME, 8'h20, 8'h30,
                       ST_SONG_POS, 8'h01, 8'h02,
                       ST_SYSEX_START, 8'h01, 8'h02, 8'h03, ST_SYSEX_END};
      apply_config(1'b0, 4'h0, 1'b1);
      for (i = 0; i < 25; i++)
         send_byte(directed_seq[i]);
      wait_until_idle();

      // implant highest channel, with a long receiver hold-off
      apply_config(1'b1, 4'hF, 1'b1);
      hold_request = 1'b1;
      send_traffic(250);
      wait_until_idle();

      // implant lowest channel
      apply_config(1'b1, 4'h0, 1'b1);
      no_idle = 1'b1;
      send_traffic(250);
      wait_until_idle();

      // pass-through with some channel left in the register
      apply_config(1'b0, 4'($urandom_range(0, 15)), 1'b1);
      no_idle = 1'b0;
      send_traffic(250);
      wait_until_idle();

      // capture off: everything dropped, parsing carries on
      apply_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b0);
      send_traffic(120);
      wait_until_idle();

      // capture back on mid-stream state, another long hold-off
      apply_config(1'b1, 4'($urandom_range(0, 15)), 1'b1);
      hold_request = 1'b1;
      send_traffic(250);
      wait_until_idle();

      apply_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), 1'b1);
      send_traffic(250);
      wait_until_idle();
      repeat (8) @(posedge clock);

      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
src/mbsp_pkg.sv
src/mbsp_parser.sv
src/midi_byte_stream_parser_top.sv
tb/sv/midi_parser_tb_pkg.sv
tb/sv/testbench.sv
